// ===== rtl/motion_stroke_detector_defines.svh =====
// Assertion macros for the motion stroke detector.
// Used by the top level only; relies on clk and rst in the calling scope.
`ifndef MOTION_STROKE_DETECTOR_DEFINES_SVH
`define MOTION_STROKE_DETECTOR_DEFINES_SVH
`ifndef SYNTHESIS
`define MSD_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("msd: same-cycle check failed");
`define MSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("msd: next-cycle check failed");
`else
`define MSD_ASSERT_IMPLIES(label, ante, cons)
`define MSD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/msd_pkg.sv =====
// Shared types and constants of the motion stroke detector.
// No dependencies; imported by msd_alu, msd_core and the top level.
package msd_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int SLOPE_BITS   = SAMPLE_BITS + 1;
  localparam int THR_BITS     = 17;
  localparam int NOTE_BITS    = 17;
  localparam int SUM_BITS     = 32;
  localparam int AVG_BITS     = SUM_BITS + 1;
  localparam int ALU_BITS     = SUM_BITS + 2;
  localparam int COUNT_BITS   = 9;
  localparam int MAXS_BITS    = 8;
  localparam int WARM_BITS    = 4;
  localparam int CFG_IDX_BITS = 3;
  localparam int DIV_STEPS    = SUM_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

  localparam int MIN_SAMPLES  = 3;
  localparam int WARMUP_COUNT = 3;
  localparam int NOTE_MAX     = 65535;

  localparam logic [COUNT_BITS-1:0]   RESTART_COUNT = COUNT_BITS'(2);
  localparam logic [DIV_CNT_BITS-1:0] DIV_LAST      = DIV_CNT_BITS'(DIV_STEPS - 1);
  localparam logic signed [NOTE_BITS-1:0] NOTE_HI   = NOTE_BITS'(NOTE_MAX);
  localparam logic signed [NOTE_BITS-1:0] NOTE_LO   = -NOTE_HI;

  // register reset values
  localparam logic signed [THR_BITS-1:0] RISE_ADJ_RST  = THR_BITS'(200);
  localparam logic signed [THR_BITS-1:0] RISE_SPAN_RST = THR_BITS'(300);
  localparam logic signed [THR_BITS-1:0] FALL_ADJ_RST  = -THR_BITS'(200);
  localparam logic signed [THR_BITS-1:0] FALL_SPAN_RST = -THR_BITS'(300);
  localparam logic signed [THR_BITS-1:0] MIN_AVG_RST   = THR_BITS'(100);
  localparam logic [MAXS_BITS-1:0]       MAX_SAMP_RST  = MAXS_BITS'(40);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RISE_OLD  = 3'd0,
    REG_RISE_NEW  = 3'd1,
    REG_RISE_SPAN = 3'd2,
    REG_FALL_OLD  = 3'd3,
    REG_FALL_NEW  = 3'd4,
    REG_FALL_SPAN = 3'd5,
    REG_MIN_AVG   = 3'd6,
    REG_MAX_SAMP  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [THR_BITS-1:0] rise_old;
    logic signed [THR_BITS-1:0] rise_new;
    logic signed [THR_BITS-1:0] rise_span;
    logic signed [THR_BITS-1:0] fall_old;
    logic signed [THR_BITS-1:0] fall_new;
    logic signed [THR_BITS-1:0] fall_span;
    logic signed [THR_BITS-1:0] min_average;
    logic [MAXS_BITS-1:0]       max_samples;
  } msd_cfg_t;

  typedef struct packed {
    logic idle;
    logic done;
  } msd_status_t;

  typedef struct packed {
    logic signed [NOTE_BITS-1:0] note_value;
    logic                        note_valid;
    logic                        rising_now;
    logic                        falling_now;
  } msd_result_t;

endpackage

// ===== rtl/msd_alu.sv =====
// Shared add/subtract unit of the stroke detector datapath.
// Depends on msd_pkg for the operand width.
module msd_alu import msd_pkg::*; (
  input  logic signed [ALU_BITS-1:0] a,
  input  logic signed [ALU_BITS-1:0] b,
  input  logic                       sub,
  output logic signed [ALU_BITS-1:0] r
);

  logic [ALU_BITS-1:0] b_eff;

  assign b_eff = sub ? ~b : b;
  assign r     = a + b_eff + ALU_BITS'(sub);

endmodule

// ===== rtl/msd_core.sv =====
// Sequencer and state of the stroke detector: window, slopes, run sum, divide.
// Depends on msd_pkg and msd_alu; slope, threshold, sum, divide and clamp steps use the one ALU.
module msd_core import msd_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          take,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  msd_cfg_t                      cfg,
  output msd_status_t                   status,
  output msd_result_t                   result
);

  typedef enum logic [21:0] {
    ST_IDLE       = 22'h000001,
    ST_SLOPE_A    = 22'h000002,
    ST_SLOPE_B    = 22'h000004,
    ST_SLOPE_C    = 22'h000008,
    ST_TEST_A     = 22'h000010,
    ST_TEST_B     = 22'h000020,
    ST_TEST_C     = 22'h000040,
    ST_VALLEY_A   = 22'h000080,
    ST_VALLEY_B   = 22'h000100,
    ST_ADD_NEW    = 22'h000200,
    ST_ADD_MID    = 22'h000400,
    ST_SUB_BASE_A = 22'h000800,
    ST_SUB_BASE_B = 22'h001000,
    ST_CHECK      = 22'h002000,
    ST_ABS        = 22'h004000,
    ST_DIV        = 22'h008000,
    ST_SIGN       = 22'h010000,
    ST_AVG_CHK    = 22'h020000,
    ST_SAT_HI     = 22'h040000,
    ST_SAT_LO     = 22'h080000,
    ST_WRAP       = 22'h100000,
    ST_DONE       = 22'h200000
  } state_t;

  state_t state;

  logic signed [SAMPLE_BITS-1:0] oldest, middle, newest, base_level;
  logic signed [SLOPE_BITS-1:0]  slope_a, slope_b, slope_c;
  logic [WARM_BITS-1:0]          warmup_count;
  logic                          rising, falling;
  logic signed [SUM_BITS-1:0]    running_sum;
  logic [COUNT_BITS-1:0]         sample_count;

  logic                          hit, valley, new_run, sum_neg, note_ok;
  logic [SUM_BITS-1:0]           quot;
  logic [COUNT_BITS-1:0]         rem;
  logic [DIV_CNT_BITS-1:0]       div_cnt;
  logic signed [AVG_BITS-1:0]    avg;
  logic signed [NOTE_BITS-1:0]   note;

  logic signed [ALU_BITS-1:0]    alu_a, alu_b, alu_r;
  logic                          alu_sub, alu_neg, hit_all, window_ready, eligible, abort;
  logic [COUNT_BITS:0]           trial;

  msd_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .r   (alu_r)
  );

  assign alu_neg      = alu_r[ALU_BITS-1];
  assign hit_all      = hit | alu_neg;
  assign window_ready = (warmup_count >= WARM_BITS'(WARMUP_COUNT));
  assign trial        = {rem, quot[SUM_BITS-1]};
  assign eligible     = falling && (sample_count >= COUNT_BITS'(MIN_SAMPLES)) &&
                        (sample_count <= COUNT_BITS'(cfg.max_samples));
  assign abort        = falling || (rising && (sample_count > COUNT_BITS'(cfg.max_samples)));

  // operand selection for the shared unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    case (state)
      ST_SLOPE_A: begin
        alu_a = ALU_BITS'(middle);
        alu_b = ALU_BITS'(oldest);
      end
      ST_SLOPE_B: begin
        alu_a = ALU_BITS'(newest);
        alu_b = ALU_BITS'(middle);
      end
      ST_SLOPE_C: begin
        alu_a = ALU_BITS'(newest);
        alu_b = ALU_BITS'(oldest);
      end
      // rising: slope < fall threshold; idle: slope > rise threshold
      ST_TEST_A: begin
        if (rising) begin
          alu_a = ALU_BITS'(slope_a);
          alu_b = ALU_BITS'(cfg.fall_old);
        end else begin
          alu_a = ALU_BITS'(cfg.rise_old);
          alu_b = ALU_BITS'(slope_a);
        end
      end
      ST_TEST_B: begin
        if (rising) begin
          alu_a = ALU_BITS'(slope_b);
          alu_b = ALU_BITS'(cfg.fall_new);
        end else begin
          alu_a = ALU_BITS'(cfg.rise_new);
          alu_b = ALU_BITS'(slope_b);
        end
      end
      ST_TEST_C: begin
        if (rising) begin
          alu_a = ALU_BITS'(slope_c);
          alu_b = ALU_BITS'(cfg.fall_span);
        end else begin
          alu_a = ALU_BITS'(cfg.rise_span);
          alu_b = ALU_BITS'(slope_c);
        end
      end
      ST_VALLEY_A: begin
        alu_a = ALU_BITS'(middle);
        alu_b = ALU_BITS'(oldest);
      end
      ST_VALLEY_B: begin
        alu_a = ALU_BITS'(middle);
        alu_b = ALU_BITS'(newest);
      end
      ST_ADD_NEW: begin
        alu_a   = ALU_BITS'(running_sum);
        alu_b   = ALU_BITS'(newest);
        alu_sub = 1'b0;
      end
      ST_ADD_MID: begin
        alu_a   = ALU_BITS'(running_sum);
        alu_b   = ALU_BITS'(middle);
        alu_sub = 1'b0;
      end
      ST_SUB_BASE_A, ST_SUB_BASE_B: begin
        alu_a = ALU_BITS'(running_sum);
        alu_b = ALU_BITS'(base_level);
      end
      ST_ABS: begin
        alu_b = ALU_BITS'(running_sum);
      end
      ST_DIV: begin
        alu_a = ALU_BITS'(trial);
        alu_b = ALU_BITS'(sample_count);
      end
      ST_SIGN: begin
        alu_b = ALU_BITS'(quot);
      end
      ST_AVG_CHK: begin
        alu_a = ALU_BITS'(avg);
        alu_b = ALU_BITS'(cfg.min_average);
      end
      ST_SAT_HI: begin
        alu_a = ALU_BITS'(NOTE_HI);
        alu_b = ALU_BITS'(avg);
      end
      ST_SAT_LO: begin
        alu_a = ALU_BITS'(avg);
        alu_b = ALU_BITS'(NOTE_LO);
      end
      default: begin
        alu_sub = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      oldest       <= '0;
      middle       <= '0;
      newest       <= '0;
      slope_a      <= '0;
      slope_b      <= '0;
      slope_c      <= '0;
      warmup_count <= '0;
      rising       <= 1'b0;
      falling      <= 1'b0;
      base_level   <= '0;
      running_sum  <= '0;
      sample_count <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            oldest  <= middle;
            middle  <= newest;
            newest  <= sample;
            if (warmup_count < WARM_BITS'(WARMUP_COUNT)) begin
              warmup_count <= warmup_count + WARM_BITS'(1);
            end
            hit     <= 1'b0;
            falling <= 1'b0;
            note    <= '0;
            note_ok <= 1'b0;
            state   <= ST_SLOPE_A;
          end
        end
        // slopes hold their old values until the window fills
        ST_SLOPE_A: begin
          if (window_ready) slope_a <= alu_r[SLOPE_BITS-1:0];
          state <= ST_SLOPE_B;
        end
        ST_SLOPE_B: begin
          if (window_ready) slope_b <= alu_r[SLOPE_BITS-1:0];
          state <= ST_SLOPE_C;
        end
        ST_SLOPE_C: begin
          if (window_ready) slope_c <= alu_r[SLOPE_BITS-1:0];
          state <= ST_TEST_A;
        end
        ST_TEST_A: begin
          hit   <= hit_all;
          state <= ST_TEST_B;
        end
        ST_TEST_B: begin
          hit   <= hit_all;
          state <= ST_TEST_C;
        end
        ST_TEST_C: begin
          if (rising) begin
            falling <= hit_all;
            new_run <= 1'b0;
            state   <= hit_all ? ST_CHECK : ST_ADD_NEW;
          end else begin
            rising  <= hit_all;
            new_run <= 1'b1;
            if (hit_all) begin
              state <= ST_VALLEY_A;
            end else begin
              running_sum <= '0;
              state       <= ST_CHECK;
            end
          end
        end
        ST_VALLEY_A: begin
          valley <= alu_neg;
          state  <= ST_VALLEY_B;
        end
        ST_VALLEY_B: begin
          // strict valley at the middle sample re-bases the stroke
          if (valley && alu_neg) begin
            base_level <= middle;
            oldest     <= middle;
          end else begin
            base_level <= oldest;
          end
          state <= ST_ADD_NEW;
        end
        ST_ADD_NEW: begin
          running_sum <= alu_r[SUM_BITS-1:0];
          state       <= new_run ? ST_ADD_MID : ST_SUB_BASE_B;
        end
        ST_ADD_MID: begin
          running_sum <= alu_r[SUM_BITS-1:0];
          state       <= ST_SUB_BASE_A;
        end
        ST_SUB_BASE_A: begin
          running_sum <= alu_r[SUM_BITS-1:0];
          state       <= ST_SUB_BASE_B;
        end
        ST_SUB_BASE_B: begin
          running_sum  <= alu_r[SUM_BITS-1:0];
          sample_count <= sample_count + COUNT_BITS'(1);
          state        <= ST_CHECK;
        end
        ST_CHECK: begin
          state <= eligible ? ST_ABS : ST_WRAP;
        end
        ST_ABS: begin
          sum_neg <= running_sum[SUM_BITS-1];
          quot    <= running_sum[SUM_BITS-1] ? alu_r[SUM_BITS-1:0] : running_sum;
          rem     <= '0;
          div_cnt <= '0;
          state   <= ST_DIV;
        end
        // restoring divide of |sum| by the count, one quotient bit per cycle
        ST_DIV: begin
          rem     <= alu_neg ? trial[COUNT_BITS-1:0] : alu_r[COUNT_BITS-1:0];
          quot    <= {quot[SUM_BITS-2:0], ~alu_neg};
          div_cnt <= div_cnt + DIV_CNT_BITS'(1);
          if (div_cnt == DIV_LAST) state <= ST_SIGN;
        end
        ST_SIGN: begin
          avg   <= sum_neg ? alu_r[AVG_BITS-1:0] : {1'b0, quot};
          state <= ST_AVG_CHK;
        end
        ST_AVG_CHK: begin
          state <= alu_neg ? ST_WRAP : ST_SAT_HI;
        end
        ST_SAT_HI: begin
          if (alu_neg) begin
            note    <= NOTE_HI;
            note_ok <= 1'b1;
            state   <= ST_WRAP;
          end else begin
            state <= ST_SAT_LO;
          end
        end
        ST_SAT_LO: begin
          note    <= alu_neg ? NOTE_LO : avg[NOTE_BITS-1:0];
          note_ok <= 1'b1;
          state   <= ST_WRAP;
        end
        ST_WRAP: begin
          // falling keeps this step's value for the result
          if (abort) begin
            rising       <= 1'b0;
            running_sum  <= '0;
            base_level   <= '0;
            sample_count <= RESTART_COUNT;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (take) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign status.idle         = (state == ST_IDLE);
  assign status.done         = (state == ST_DONE);
  assign result.note_value   = note;
  assign result.note_valid   = note_ok;
  assign result.rising_now   = rising;
  assign result.falling_now  = falling;

endmodule

// ===== rtl/motion_stroke_detector.sv =====
// Top level of the motion stroke detector: register file, core, result register.
// Depends on msd_pkg, msd_core (with msd_alu) and motion_stroke_detector_defines.svh.
//
// channel  | handshake                 | payload
// ---------+---------------------------+--------------------------------------------
// sample   | sample_valid/sample_ready | sample
// result   | result_valid/result_ready | note_value, note_valid, rising_now, falling_now
// cfg      | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
// Each sample is processed from its transfer through to its result before the next sample
// can transfer; the longest path is a completed stroke, set by the 32-step serial divide on
// the shared ALU. sample_ready is high only while the core is idle. A finished result
// moves into the output register as soon as that register is free, so a stalled result
// channel holds the core only after the next sample. Synchronous reset restores register
// defaults and clears the sequencer, window, slope, run and count state and result_valid.
`include "motion_stroke_detector_defines.svh"

module motion_stroke_detector import msd_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  output logic                           sample_ready,
  input  logic signed [SAMPLE_BITS-1:0]  sample,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic signed [NOTE_BITS-1:0]    note_value,
  output logic                           note_valid,
  output logic                           rising_now,
  output logic                           falling_now,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]        cfg_index,
  input  logic [THR_BITS-1:0]            cfg_data
);

  msd_cfg_t    cfg;
  msd_status_t status;
  msd_result_t result;
  logic        take;

  assign cfg_ready    = 1'b1;
  assign sample_ready = status.idle;
  assign take         = status.done && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rise_old    <= RISE_ADJ_RST;
      cfg.rise_new    <= RISE_ADJ_RST;
      cfg.rise_span   <= RISE_SPAN_RST;
      cfg.fall_old    <= FALL_ADJ_RST;
      cfg.fall_new    <= FALL_ADJ_RST;
      cfg.fall_span   <= FALL_SPAN_RST;
      cfg.min_average <= MIN_AVG_RST;
      cfg.max_samples <= MAX_SAMP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_RISE_OLD:  cfg.rise_old    <= cfg_data;
        REG_RISE_NEW:  cfg.rise_new    <= cfg_data;
        REG_RISE_SPAN: cfg.rise_span   <= cfg_data;
        REG_FALL_OLD:  cfg.fall_old    <= cfg_data;
        REG_FALL_NEW:  cfg.fall_new    <= cfg_data;
        REG_FALL_SPAN: cfg.fall_span   <= cfg_data;
        REG_MIN_AVG:   cfg.min_average <= cfg_data;
        REG_MAX_SAMP:  cfg.max_samples <= cfg_data[MAXS_BITS-1:0];
        default: begin
          cfg.max_samples <= cfg.max_samples;
        end
      endcase
    end
  end

  msd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .start  (sample_valid && sample_ready),
    .take   (take),
    .sample (sample),
    .cfg    (cfg),
    .status (status),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      note_value  <= result.note_value;
      note_valid  <= result.note_valid;
      rising_now  <= result.rising_now;
      falling_now <= result.falling_now;
    end
  end

  `MSD_ASSERT_NEXT(a_busy_after_transfer, sample_valid && sample_ready, !sample_ready)
  `MSD_ASSERT_IMPLIES(a_note_needs_fall, result_valid && note_valid, falling_now && !rising_now)
  `MSD_ASSERT_IMPLIES(a_no_note_is_zero, result_valid && !note_valid, note_value == '0)
  `MSD_ASSERT_IMPLIES(a_note_in_range, result_valid && note_valid, note_value >= NOTE_LO)

endmodule
